>>> src/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg: shared types and constants of the positional ordered list.
// Field widths, command and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pol_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CMD_W     = 2;
	localparam int POS_W     = 8;
	localparam int DATA_W    = 16;
	localparam int STAT_W    = 2;
	localparam int LEN_W     = 5;
	localparam int REC_W     = 3 * DATA_W;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Outcome of a command, decided once the word has been latched.
	typedef enum logic [2:0] {
		K_NONE,
		K_RANGE,
		K_FULL,
		K_INS,
		K_DEL,
		K_RD
	} kind_t;

	typedef struct packed {
		logic take;
		logic init_idx;
		logic step_idx;
		logic move_wr;
		logic put_wr;
		logic capture;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  move_pending;
	} dp_stat_t;

endpackage

>>> src/pol_ram.sv
// ----------------------------------------------------------------------------
// pol_ram: generic single-write, single-read RAM.
// The read data is registered; contents are not reset.
// ----------------------------------------------------------------------------
module pol_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/pol_ctrl.sv
// ----------------------------------------------------------------------------
// pol_ctrl: sequencing of one command word.
// Drives the input and output handshakes and steps the datapath through the
// entry moves of an insert or delete.
// ----------------------------------------------------------------------------
module pol_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  pol_pkg::dp_stat_t st,
	output pol_pkg::dp_cmd_t  cmd
);

	import pol_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EVAL = 7'b0000010,
		S_CHK  = 7'b0000100,
		S_RD   = 7'b0001000,
		S_WR   = 7'b0010000,
		S_PUT  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   cap_pend_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take  = 1'b1;
					state_nxt = S_EVAL;
				end
			end
			S_EVAL: begin
				case (st.kind)
					K_INS, K_DEL: begin
						cmd.init_idx = 1'b1;
						state_nxt    = S_CHK;
					end
					K_RD: begin
						state_nxt = S_RD;
					end
					default: begin
						state_nxt = S_DONE;
					end
				endcase
			end
			S_CHK: begin
				if (st.move_pending) begin
					state_nxt = S_RD;
				end else if (st.kind == K_INS) begin
					state_nxt = S_PUT;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_RD: begin
				// A plain read has its record in the RAM output register next cycle.
				state_nxt = (st.kind == K_RD) ? S_PUT : S_WR;
			end
			S_WR: begin
				cmd.move_wr  = 1'b1;
				cmd.step_idx = 1'b1;
				state_nxt    = S_CHK;
			end
			S_PUT: begin
				if (st.kind == K_RD) begin
					cmd.capture = 1'b1;
				end else begin
					cmd.put_wr = 1'b1;
				end
				state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cap_pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			cap_pend_q <= cmd.capture;
		end
	end

	assign in_stall  = (state_q != S_IDLE) || cap_pend_q;
	assign out_valid = out_valid_q;

endmodule

>>> src/pol_dp.sv
// ----------------------------------------------------------------------------
// pol_dp: datapath of the positional ordered list.
// Holds the latched word, the entry count, the move index, the entry RAM and
// the result register.
// ----------------------------------------------------------------------------
module pol_dp #(
	parameter int DEPTH = pol_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pol_pkg::dp_cmd_t            cmd,
	output pol_pkg::dp_stat_t           st,
	input  logic [pol_pkg::CMD_W-1:0]   cmd_code,
	input  logic [pol_pkg::POS_W-1:0]   position,
	input  logic [pol_pkg::DATA_W-1:0]  car_number,
	input  logic [pol_pkg::DATA_W-1:0]  car_capacity,
	input  logic [pol_pkg::DATA_W-1:0]  car_passengers,
	output logic [pol_pkg::STAT_W-1:0]  status,
	output logic [pol_pkg::DATA_W-1:0]  read_number,
	output logic [pol_pkg::DATA_W-1:0]  read_capacity,
	output logic [pol_pkg::DATA_W-1:0]  read_passengers,
	output logic [pol_pkg::LEN_W-1:0]   length
);

	import pol_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CMD_W-1:0]  cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [REC_W-1:0]  rec_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [REC_W-1:0]  hold_q;
	logic [STAT_W-1:0] status_q;
	logic [REC_W-1:0]  rd_rec_q;
	logic [LEN_W-1:0]  length_q;

	logic [CMPW-1:0]   pos_ext;
	logic [CMPW-1:0]   pos_m1;
	logic [CMPW-1:0]   cnt_ext;
	logic [CMPW-1:0]   idx_ext;
	logic [CW-1:0]     slot;
	logic [CW-1:0]     count_nxt;
	logic [CMPW-1:0]   len_ext;
	logic [CW-1:0]     src_idx;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [REC_W-1:0]  wdata;
	logic              we;
	logic [REC_W-1:0]  ram_rdata;
	kind_t             kind;

	assign pos_ext = CMPW'(pos_q);
	assign pos_m1  = pos_ext - CMPW'(1);
	assign cnt_ext = CMPW'(count_q);
	assign idx_ext = CMPW'(idx_q);

	// An insert beyond the end lands at the tail.
	assign slot = (pos_m1 > cnt_ext) ? count_q : pos_m1[CW-1:0];

	always_comb begin
		case (cmd_q)
			CMD_INSERT: begin
				if (pos_q == '0) begin
					kind = K_RANGE;
				end else if (cnt_ext >= CMPW'(DEPTH)) begin
					kind = K_FULL;
				end else begin
					kind = K_INS;
				end
			end
			CMD_DELETE: begin
				kind = (pos_q == '0 || pos_ext > cnt_ext) ? K_RANGE : K_DEL;
			end
			CMD_READ: begin
				kind = (pos_q == '0 || pos_ext > cnt_ext) ? K_RANGE : K_RD;
			end
			default: begin
				kind = K_NONE;
			end
		endcase
	end

	assign st.kind         = kind;
	assign st.move_pending = (kind == K_INS) ? (idx_q > slot)
	                                         : ((idx_ext + CMPW'(1)) < cnt_ext);

	// Source of the entry that moves into idx: the one below on insert, above on delete.
	always_comb begin
		case (kind)
			K_INS:   src_idx = idx_q - CW'(1);
			K_DEL:   src_idx = idx_q + CW'(1);
			default: src_idx = pos_m1[CW-1:0];
		endcase
	end

	assign raddr = src_idx[AW-1:0];
	assign waddr = idx_q[AW-1:0];
	assign we    = cmd.move_wr | cmd.put_wr;
	assign wdata = cmd.move_wr ? ram_rdata : rec_q;

	pol_ram #(
		.WIDTH (REC_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		case (kind)
			K_INS:   count_nxt = count_q + CW'(1);
			K_DEL:   count_nxt = count_q - CW'(1);
			default: count_nxt = count_q;
		endcase
	end

	assign len_ext = CMPW'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.finish) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q <= cmd_code;
			pos_q <= position;
			rec_q <= {car_number, car_capacity, car_passengers};
		end
		if (cmd.init_idx) begin
			idx_q <= (kind == K_INS) ? count_q : pos_m1[CW-1:0];
		end else if (cmd.step_idx) begin
			idx_q <= src_idx;
		end
		if (cmd.capture) begin
			hold_q <= ram_rdata;
		end
		if (cmd.finish) begin
			case (kind)
				K_RANGE: status_q <= ST_RANGE;
				K_FULL:  status_q <= ST_FULL;
				default: status_q <= ST_DONE;
			endcase
			rd_rec_q <= (kind == K_RD) ? hold_q : '0;
			length_q <= len_ext[LEN_W-1:0];
		end
	end

	assign status          = status_q;
	assign read_number     = rd_rec_q[3*DATA_W-1:2*DATA_W];
	assign read_capacity   = rd_rec_q[2*DATA_W-1:DATA_W];
	assign read_passengers = rd_rec_q[DATA_W-1:0];
	assign length          = length_q;

endmodule

>>> src/positional_ordered_list_core.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_core: bounded list of car records by position.
// Insert, delete and read at a 1-based position; one result word per command.
// ----------------------------------------------------------------------------
// A command word enters on the in channel (in_valid/in_stall) and exactly one
// result word leaves on the out channel (out_valid/out_stall). A word moves at
// a rising edge where valid is high and stall is low.
// Entries live in a single RAM with one write and one registered read port,
// so an insert or delete shuffles the entries behind the position one at a
// time, each moved entry passing through a check, a RAM read and a write step.
// A read passes through evaluation, a RAM read and a capture of the record; an
// insert ends by writing the new record into its slot; at most DEPTH - 1
// entries are moved. The block takes one command at a time and is open for
// the next one once the result has been loaded.
// Reset empties the list at once; the RAM is not cleared, as only positions
// below the entry count are ever read. While the receiver stalls, the result
// word holds; a following command is still accepted and processed, and it
// waits for the output register to free before loading its own result.
// ----------------------------------------------------------------------------
module positional_ordered_list_core #(
	parameter int DEPTH = pol_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pol_pkg::CMD_W-1:0]   cmd,
	input  logic [pol_pkg::POS_W-1:0]   position,
	input  logic [pol_pkg::DATA_W-1:0]  car_number,
	input  logic [pol_pkg::DATA_W-1:0]  car_capacity,
	input  logic [pol_pkg::DATA_W-1:0]  car_passengers,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pol_pkg::STAT_W-1:0]  status,
	output logic [pol_pkg::DATA_W-1:0]  read_number,
	output logic [pol_pkg::DATA_W-1:0]  read_capacity,
	output logic [pol_pkg::DATA_W-1:0]  read_passengers,
	output logic [pol_pkg::LEN_W-1:0]   length
);

	import pol_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	pol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (dp_stat),
		.cmd       (dp_cmd)
	);

	pol_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (dp_cmd),
		.st              (dp_stat),
		.cmd_code        (cmd),
		.position        (position),
		.car_number      (car_number),
		.car_capacity    (car_capacity),
		.car_passengers  (car_passengers),
		.status          (status),
		.read_number     (read_number),
		.read_capacity   (read_capacity),
		.read_passengers (read_passengers),
		.length          (length)
	);

endmodule

>>> src/pol_checker.sv
// ----------------------------------------------------------------------------
// pol_checker: port-level checks of the positional ordered list.
// Bound to the top level; watches its handshakes and result words.
// ----------------------------------------------------------------------------
module pol_checker #(
	parameter int DEPTH = pol_pkg::DEPTH_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [pol_pkg::STAT_W-1:0] status,
	input logic [pol_pkg::DATA_W-1:0] read_number,
	input logic [pol_pkg::DATA_W-1:0] read_capacity,
	input logic [pol_pkg::DATA_W-1:0] read_passengers,
	input logic [pol_pkg::LEN_W-1:0]  length
);

	import pol_pkg::*;

	localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH % 32);

	// One command at a time: the block closes its input after taking a word.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("pol: second word taken while a command is in progress");

	// Record fields are only filled by a successful read.
	a_fail_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |->
			read_number == '0 && read_capacity == '0 && read_passengers == '0)
		else $error("pol: record fields set on a failed command");

	// A full report means the list holds every entry.
	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> length == FULL_LEN)
		else $error("pol: list full reported with a short length");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			out_valid && $stable(status) && $stable(length) && $stable(read_number))
		else $error("pol: stalled result word changed");

endmodule

bind positional_ordered_list_core pol_checker #(
	.DEPTH (DEPTH)
) u_pol_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.read_number     (read_number),
	.read_capacity   (read_capacity),
	.read_passengers (read_passengers),
	.length          (length)
);
